FILE: rtl/mpa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpa_pkg
// Shared constants, types and helpers of the max pooling with argmax block.
// ----------------------------------------------------------------------------
package mpa_pkg;

  localparam int DATA_BITS    = 16;
  localparam int INDEX_BITS   = 28;
  localparam int MAX_WIDTH    = 1024;
  localparam int COL_BITS     = $clog2(MAX_WIDTH);
  localparam int MAX_WINDOW   = 16;
  localparam int WIN_BITS     = $clog2(MAX_WINDOW);
  localparam int MAX_CHANNELS = 256;
  localparam int CHAN_BITS    = $clog2(MAX_CHANNELS);

  localparam int DIM_BITS  = 11;
  localparam int CNT_BITS  = 9;
  localparam int WSZ_BITS  = 5;
  localparam int CFG_BITS  = 11;
  localparam int CIDX_BITS = 3;

  localparam logic [CIDX_BITS-1:0] REG_IN_HEIGHT     = 3'd0;
  localparam logic [CIDX_BITS-1:0] REG_IN_WIDTH      = 3'd1;
  localparam logic [CIDX_BITS-1:0] REG_CHANNEL_COUNT = 3'd2;
  localparam logic [CIDX_BITS-1:0] REG_WINDOW_HEIGHT = 3'd3;
  localparam logic [CIDX_BITS-1:0] REG_WINDOW_WIDTH  = 3'd4;

  localparam logic [DIM_BITS-1:0] RESET_IN_HEIGHT     = 11'd28;
  localparam logic [DIM_BITS-1:0] RESET_IN_WIDTH      = 11'd28;
  localparam logic [CNT_BITS-1:0] RESET_CHANNEL_COUNT = 9'd1;
  localparam logic [WSZ_BITS-1:0] RESET_WINDOW_HEIGHT = 5'd2;
  localparam logic [WSZ_BITS-1:0] RESET_WINDOW_WIDTH  = 5'd2;

  typedef struct packed {
    logic [DIM_BITS-1:0] height;
    logic [DIM_BITS-1:0] width;
    logic [CNT_BITS-1:0] channels;
    logic [WSZ_BITS-1:0] win_height;
    logic [WSZ_BITS-1:0] win_width;
  } geom_t;

  typedef struct packed {
    logic [COL_BITS-1:0]          slot;
    logic signed [DATA_BITS-1:0]  sample;
    logic [INDEX_BITS-1:0]        flat;
    logic                         first;
    logic                         emit;
    logic                         last;
  } scan_t;

  typedef struct packed {
    logic signed [DATA_BITS-1:0] max_value;
    logic [INDEX_BITS-1:0]       source;
  } entry_t;

  // A zero reads as one, anything above the bound reads as the bound.
  function automatic logic [DIM_BITS-1:0] clamp_reg(input logic [DIM_BITS-1:0] value,
                                                    input logic [DIM_BITS-1:0] bound);
    logic [DIM_BITS-1:0] result;
    if (value == '0) begin
      result = {{(DIM_BITS-1){1'b0}}, 1'b1};
    end else if (value > bound) begin
      result = bound;
    end else begin
      result = value;
    end
    return result;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/mpa_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpa_in_if
// Sample request channel with valid and ready.
// ----------------------------------------------------------------------------
interface mpa_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mpa_pkg::DATA_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface
`default_nettype wire

FILE: rtl/mpa_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpa_out_if
// Pooled result request channel with valid and ready.
// ----------------------------------------------------------------------------
interface mpa_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mpa_pkg::DATA_BITS-1:0] max_value;
  logic [mpa_pkg::INDEX_BITS-1:0]       source_index;
  logic                                 last_of_map;

  modport source (output valid, output max_value, output source_index,
                  output last_of_map, input ready);
  modport sink (input valid, input max_value, input source_index,
                input last_of_map, output ready);
endinterface
`default_nettype wire

FILE: rtl/mpa_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpa_scan
// Scan position counters. Tags each accepted sample with its column store
// slot, flat index and window position.
// ----------------------------------------------------------------------------
module mpa_scan (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire mpa_pkg::geom_t                       geom,
  input  wire logic                                 accept,
  input  wire logic signed [mpa_pkg::DATA_BITS-1:0] sample,
  output mpa_pkg::scan_t                            req
);

  logic [mpa_pkg::COL_BITS-1:0]   col_pos;
  logic [mpa_pkg::COL_BITS-1:0]   row_pos;
  logic [mpa_pkg::CHAN_BITS-1:0]  channel_pos;
  logic [mpa_pkg::WIN_BITS-1:0]   row_in_window;
  logic [mpa_pkg::WIN_BITS-1:0]   col_in_window;
  logic [mpa_pkg::COL_BITS-1:0]   out_col_pos;
  logic [mpa_pkg::INDEX_BITS-1:0] flat_pos;

  logic row_end;
  logic col_end;
  logic chan_end;
  logic win_last_col;
  logic win_last_row;

  always_comb begin
    row_end  = ({1'b0, col_pos} + 1'b1) >= geom.width;
    col_end  = ({1'b0, row_pos} + 1'b1) >= geom.height;
    chan_end = ({1'b0, channel_pos} + 1'b1) >= geom.channels;
    win_last_col = (({1'b0, col_in_window} + 1'b1) >= geom.win_width) || row_end;
    win_last_row = (({1'b0, row_in_window} + 1'b1) >= geom.win_height) || col_end;

    req.slot   = out_col_pos;
    req.sample = sample;
    req.flat   = flat_pos;
    req.first  = (row_in_window == '0) && (col_in_window == '0);
    req.emit   = win_last_col && win_last_row;
    req.last   = row_end && col_end && chan_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos       <= '0;
      row_pos       <= '0;
      channel_pos   <= '0;
      row_in_window <= '0;
      col_in_window <= '0;
      out_col_pos   <= '0;
      flat_pos      <= '0;
    end else if (accept) begin
      flat_pos <= flat_pos + 1'b1;
      if (row_end) begin
        col_pos       <= '0;
        col_in_window <= '0;
        out_col_pos   <= '0;
        if (col_end) begin
          row_pos       <= '0;
          row_in_window <= '0;
          if (chan_end) begin
            channel_pos <= '0;
            flat_pos    <= '0;
          end else begin
            channel_pos <= channel_pos + 1'b1;
          end
        end else begin
          row_pos <= row_pos + 1'b1;
          if (win_last_row) begin
            row_in_window <= '0;
          end else begin
            row_in_window <= row_in_window + 1'b1;
          end
        end
      end else begin
        col_pos <= col_pos + 1'b1;
        if (win_last_col) begin
          col_in_window <= '0;
          out_col_pos   <= out_col_pos + 1'b1;
        end else begin
          col_in_window <= col_in_window + 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/mpa_column_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpa_column_unit
// Column store with read-modify-write of the running maximum and its index,
// forwarding between back-to-back requests, and the result output register.
// ----------------------------------------------------------------------------
module mpa_column_unit (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  input  wire mpa_pkg::scan_t req,
  output logic                req_ready,
  output logic                res_valid,
  input  wire logic           res_ready,
  output mpa_pkg::entry_t     res_entry,
  output logic                res_last
);

  mpa_pkg::entry_t store [mpa_pkg::MAX_WIDTH];

  logic            s1_valid;
  mpa_pkg::scan_t  s1;
  mpa_pkg::entry_t rd_entry;
  logic            fwd_hit;
  mpa_pkg::entry_t fwd_entry;

  mpa_pkg::entry_t current;
  mpa_pkg::entry_t merged;
  logic            s1_adv;
  logic            wr_en;

  always_comb begin
    current = fwd_hit ? fwd_entry : rd_entry;
    if (s1.first || (s1.sample > current.max_value)) begin
      merged.max_value = s1.sample;
      merged.source    = s1.flat;
    end else begin
      merged = current;
    end
    s1_adv    = !s1.emit || !res_valid || res_ready;
    wr_en     = s1_valid && s1_adv;
    req_ready = !s1_valid || s1_adv;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[s1.slot] <= merged;
    end
    if (req_valid) begin
      rd_entry <= store[req.slot];
    end
  end

  // The request in flight writes its slot at the edge that reads the next one.
  always_ff @(posedge clk) begin
    if (req_valid) begin
      s1        <= req;
      fwd_hit   <= wr_en && (s1.slot == req.slot);
      fwd_entry <= merged;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_valid) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (wr_en && s1.emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && s1.emit) begin
      res_entry <= merged;
      res_last  <= s1.last;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/max_pool_with_argmax_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// max_pool_with_argmax_top
// Streaming 2-D max pooling with argmax over a multi-channel feature map.
// ----------------------------------------------------------------------------
// Samples arrive in channel, row, column order, one request per cycle at full
// rate; each takes one read-modify-write of the per-column store (a single
// 1024-entry memory, one read and one write port), so throughput is one
// sample per cycle unless a result waits on a stalled receiver. Back-to-back
// samples of the same window are forwarded around the memory. The store
// needs no clearing pass after reset: the first sample of each window
// overwrites its slot. Window sizes are also the strides, and partial windows
// at the right and bottom edges are emitted. Geometry registers must be
// written only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module max_pool_with_argmax_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [mpa_pkg::CIDX_BITS-1:0] cfg_index,
  input  wire logic [mpa_pkg::CFG_BITS-1:0]  cfg_data,
  mpa_in_if.sink                             samples,
  mpa_out_if.source                          results
);

  logic [mpa_pkg::DIM_BITS-1:0] in_height;
  logic [mpa_pkg::DIM_BITS-1:0] in_width;
  logic [mpa_pkg::CNT_BITS-1:0] channel_count;
  logic [mpa_pkg::WSZ_BITS-1:0] window_height;
  logic [mpa_pkg::WSZ_BITS-1:0] window_width;

  mpa_pkg::geom_t  geom;
  mpa_pkg::scan_t  req;
  mpa_pkg::entry_t res_entry;
  logic            req_ready;
  logic            accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_height     <= mpa_pkg::RESET_IN_HEIGHT;
      in_width      <= mpa_pkg::RESET_IN_WIDTH;
      channel_count <= mpa_pkg::RESET_CHANNEL_COUNT;
      window_height <= mpa_pkg::RESET_WINDOW_HEIGHT;
      window_width  <= mpa_pkg::RESET_WINDOW_WIDTH;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        mpa_pkg::REG_IN_HEIGHT:     in_height     <= cfg_data;
        mpa_pkg::REG_IN_WIDTH:      in_width      <= cfg_data;
        mpa_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_data[mpa_pkg::CNT_BITS-1:0];
        mpa_pkg::REG_WINDOW_HEIGHT: window_height <= cfg_data[mpa_pkg::WSZ_BITS-1:0];
        mpa_pkg::REG_WINDOW_WIDTH:  window_width  <= cfg_data[mpa_pkg::WSZ_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    geom.height = mpa_pkg::clamp_reg(in_height, mpa_pkg::DIM_BITS'(mpa_pkg::MAX_WIDTH));
    geom.width  = mpa_pkg::clamp_reg(in_width, mpa_pkg::DIM_BITS'(mpa_pkg::MAX_WIDTH));
    geom.channels = mpa_pkg::CNT_BITS'(mpa_pkg::clamp_reg(
        mpa_pkg::DIM_BITS'(channel_count), mpa_pkg::DIM_BITS'(mpa_pkg::MAX_CHANNELS)));
    geom.win_height = mpa_pkg::WSZ_BITS'(mpa_pkg::clamp_reg(
        mpa_pkg::DIM_BITS'(window_height), mpa_pkg::DIM_BITS'(mpa_pkg::MAX_WINDOW)));
    geom.win_width = mpa_pkg::WSZ_BITS'(mpa_pkg::clamp_reg(
        mpa_pkg::DIM_BITS'(window_width), mpa_pkg::DIM_BITS'(mpa_pkg::MAX_WINDOW)));
  end

  assign accept        = samples.valid && req_ready;
  assign samples.ready = req_ready;

  mpa_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .geom   (geom),
    .accept (accept),
    .sample (samples.sample),
    .req    (req)
  );

  mpa_column_unit u_column (
    .clk       (clk),
    .rst       (rst),
    .req_valid (accept),
    .req       (req),
    .req_ready (req_ready),
    .res_valid (results.valid),
    .res_ready (results.ready),
    .res_entry (res_entry),
    .res_last  (results.last_of_map)
  );

  assign results.max_value    = res_entry.max_value;
  assign results.source_index = res_entry.source;

endmodule
`default_nettype wire

FILE: tb/max_pool_with_argmax_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_pool_with_argmax_top_test
// Self-checking bench for the streaming max pooling with argmax block. A
// short table of hand-checked maps comes first. Random geometries and
// activations follow, with whole maps sent between geometry writes. Every
// pooled result is checked against a cycle-free model of the pooling,
// while both sides of the stream idle and stall at random.
// ----------------------------------------------------------------------------
module max_pool_with_argmax_top_test;
  import mpa_pkg::*;

  localparam int SETTLE      = 8;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int STAGE_ITEMS = 90;

  typedef struct packed {
    logic signed [DATA_BITS-1:0] max_value;
    logic [INDEX_BITS-1:0]       source_index;
    logic                        last_of_map;
  } pooled_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t                   kind;
    logic [CIDX_BITS-1:0]        index;
    logic [CFG_BITS-1:0]         data;
    logic signed [DATA_BITS-1:0] value;
    bit                          typed;
    pooled_t                     want;
  } directed_row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CIDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]  cfg_data;

  mpa_in_if  samples_ch ();
  mpa_out_if results_ch ();

  max_pool_with_argmax_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples_ch),
    .results   (results_ch)
  );

  always #6 clk = ~clk;

  logic [DIM_BITS-1:0]         geo_height, geo_width;
  logic [CNT_BITS-1:0]         geo_channels;
  logic [WSZ_BITS-1:0]         geo_win_h, geo_win_w;
  logic signed [DATA_BITS-1:0] best_value [MAX_WIDTH];
  logic [INDEX_BITS-1:0]       best_index [MAX_WIDTH];
  int unsigned                 row_at, col_at, chan_at, win_row, win_col, out_col;
  logic [INDEX_BITS-1:0]       flat_at;

  pooled_t pending_pools [$];
  int      mismatches = 0;
  int      send_idle_pct = 32;
  int      recv_idle_pct = 70;
  bit      hold_request = 1'b0;
  bit      sent_since_write = 1'b0;

  function automatic int unsigned bounded(input int unsigned raw, input int unsigned limit);
    if (raw == 0) begin
      return 1;
    end
    return raw > limit ? limit : raw;
  endfunction

  function automatic int unsigned map_samples();
    return bounded(geo_height, MAX_WIDTH) * bounded(geo_width, MAX_WIDTH) *
           bounded(geo_channels, MAX_CHANNELS);
  endfunction

  function automatic bit pool_sample(input logic signed [DATA_BITS-1:0] value,
                                     output pooled_t res);
    int unsigned h, w, c, wh, ww, slot;
    bit          row_done, rows_done, map_done, last_col, last_row;
    h = bounded(geo_height, MAX_WIDTH);
    w = bounded(geo_width, MAX_WIDTH);
    c = bounded(geo_channels, MAX_CHANNELS);
    wh = bounded(geo_win_h, MAX_WINDOW);
    ww = bounded(geo_win_w, MAX_WINDOW);
    slot = out_col < MAX_WIDTH ? out_col : MAX_WIDTH - 1;
    row_done = col_at + 1 >= w;
    rows_done = row_at + 1 >= h;
    map_done = row_done && rows_done && chan_at + 1 >= c;
    last_col = win_col + 1 >= ww || row_done;
    last_row = win_row + 1 >= wh || rows_done;

    // The first sample of a window always takes the slot; later ones only when strictly larger.
    if ((win_row == 0 && win_col == 0) || value > best_value[slot]) begin
      best_value[slot] = value;
      best_index[slot] = flat_at;
    end
    res.max_value = best_value[slot];
    res.source_index = best_index[slot];
    res.last_of_map = map_done;

    flat_at = flat_at + 1'b1;
    if (last_col) begin
      win_col = 0;
      out_col++;
    end else begin
      win_col++;
    end
    if (row_done) begin
      col_at = 0;
      win_col = 0;
      out_col = 0;
      if (last_row) begin
        win_row = 0;
      end else begin
        win_row++;
      end
      if (rows_done) begin
        row_at = 0;
        win_row = 0;
        if (chan_at + 1 >= c) begin
          chan_at = 0;
          flat_at = '0;
        end else begin
          chan_at++;
        end
      end else begin
        row_at++;
      end
    end else begin
      col_at++;
    end
    return last_col && last_row;
  endfunction

  function automatic logic signed [DATA_BITS-1:0] random_activation();
    logic signed [DATA_BITS-1:0] value;
    case ($urandom_range(0, 3))
      0, 1: begin
        value = DATA_BITS'($urandom);
      end
      2: begin
        case ($urandom_range(0, 3))
          0: value = 16'sh8000;
          1: value = 16'sh7FFF;
          2: value = '0;
          default: value = '1;
        endcase
      end
      default: begin
        value = DATA_BITS'($urandom_range(0, 7)) - 16'sd4;
      end
    endcase
    return value;
  endfunction

  function automatic directed_row_t reg_row(input logic [CIDX_BITS-1:0] index,
                                            input logic [CFG_BITS-1:0] data);
    directed_row_t row;
    row = '{ROW_WRITE, index, data, '0, 1'b0, '0};
    return row;
  endfunction

  function automatic directed_row_t sample_row(input logic signed [DATA_BITS-1:0] value);
    directed_row_t row;
    row = '{ROW_SAMPLE, REG_IN_HEIGHT, '0, value, 1'b0, '0};
    return row;
  endfunction

  function automatic directed_row_t checked_row(input logic signed [DATA_BITS-1:0] value,
                                                input logic signed [DATA_BITS-1:0] max_value,
                                                input logic [INDEX_BITS-1:0] source_index,
                                                input logic last_of_map);
    directed_row_t row;
    row = '{ROW_SAMPLE, REG_IN_HEIGHT, '0, value, 1'b1,
            pooled_t'{max_value, source_index, last_of_map}};
    return row;
  endfunction

  // Geometry is only written once the block has drained its last request.
  task automatic write_reg(input logic [CIDX_BITS-1:0] index, input logic [CFG_BITS-1:0] data);
    samples_ch.valid <= 1'b0;
    if (sent_since_write) begin
      while (pending_pools.size() != 0) @(posedge clk);
      repeat (SETTLE) @(posedge clk);
      sent_since_write = 1'b0;
    end
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (index)
      REG_IN_HEIGHT:     geo_height = data;
      REG_IN_WIDTH:      geo_width = data;
      REG_CHANNEL_COUNT: geo_channels = data[CNT_BITS-1:0];
      REG_WINDOW_HEIGHT: geo_win_h = data[WSZ_BITS-1:0];
      REG_WINDOW_WIDTH:  geo_win_w = data[WSZ_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic offer_sample(input logic signed [DATA_BITS-1:0] value, input bit typed,
                              input pooled_t want);
    pooled_t predicted;
    bit      emitted;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      samples_ch.valid <= 1'b0;
      @(posedge clk);
    end
    samples_ch.valid <= 1'b1;
    samples_ch.sample <= value;
    @(posedge clk);
    while (!samples_ch.ready) @(posedge clk);
    sent_since_write = 1'b1;
    emitted = pool_sample(value, predicted);
    if (typed) begin
      pending_pools.push_back(want);
    end else if (emitted) begin
      pending_pools.push_back(predicted);
    end
  endtask

  // The long receiver stall starts only once the geometry is written, as the samples begin.
  task automatic run_phase(input logic [CFG_BITS-1:0] h, input logic [CFG_BITS-1:0] w,
                           input logic [CFG_BITS-1:0] c, input logic [CFG_BITS-1:0] wh,
                           input logic [CFG_BITS-1:0] ww, input int maps, input bit hold,
                           output int sent);
    write_reg(REG_IN_HEIGHT, h);
    write_reg(REG_IN_WIDTH, w);
    write_reg(REG_CHANNEL_COUNT, c);
    write_reg(REG_WINDOW_HEIGHT, wh);
    write_reg(REG_WINDOW_WIDTH, ww);
    if (hold) begin
      hold_request = 1'b1;
    end
    sent = maps * map_samples();
    for (int i = 0; i < sent; i++) begin
      offer_sample(random_activation(), 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    directed_row_t          plan [$];
    int                     stage_items, sent;
    logic [CFG_BITS-1:0]    h, w, c, wh, ww;

    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    samples_ch.valid <= 1'b0;
    samples_ch.sample <= '0;

    geo_height = RESET_IN_HEIGHT;
    geo_width = RESET_IN_WIDTH;
    geo_channels = RESET_CHANNEL_COUNT;
    geo_win_h = RESET_WINDOW_HEIGHT;
    geo_win_w = RESET_WINDOW_WIDTH;
    foreach (best_value[i]) begin
      best_value[i] = '0;
      best_index[i] = '0;
    end
    row_at = 0;
    col_at = 0;
    chan_at = 0;
    win_row = 0;
    win_col = 0;
    out_col = 0;
    flat_at = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // A 3x3 map under the reset 2x2 window: ties, extremes and partial windows.
    plan.push_back(reg_row(REG_IN_HEIGHT, 11'd3));
    plan.push_back(reg_row(REG_IN_WIDTH, 11'd3));
    plan.push_back(sample_row(16'sh8000));
    plan.push_back(sample_row(16'sh8000));
    plan.push_back(sample_row(16'sh7FFF));
    plan.push_back(sample_row(16'sh8000));
    plan.push_back(checked_row(16'sh8000, 16'sh8000, 28'd0, 1'b0));
    plan.push_back(checked_row(16'sh7FFF, 16'sh7FFF, 28'd2, 1'b0));
    plan.push_back(sample_row(-16'sd1));
    plan.push_back(checked_row(16'sh0000, 16'sh0000, 28'd7, 1'b0));
    plan.push_back(checked_row(16'sh7FFF, 16'sh7FFF, 28'd8, 1'b1));
    // Two channels of 2x2; a zero window height reads as one, an oversized width as the bound.
    plan.push_back(reg_row(REG_IN_HEIGHT, 11'd2));
    plan.push_back(reg_row(REG_IN_WIDTH, 11'd2));
    plan.push_back(reg_row(REG_CHANNEL_COUNT, 11'd2));
    plan.push_back(reg_row(REG_WINDOW_HEIGHT, 11'd0));
    plan.push_back(reg_row(REG_WINDOW_WIDTH, 11'd31));
    plan.push_back(sample_row(16'sd5));
    plan.push_back(checked_row(16'sd3, 16'sd5, 28'd0, 1'b0));
    plan.push_back(sample_row(-16'sd7));
    plan.push_back(checked_row(-16'sd2, -16'sd2, 28'd3, 1'b0));
    plan.push_back(sample_row(16'sh0100));
    plan.push_back(checked_row(16'sh0100, 16'sh0100, 28'd4, 1'b0));
    plan.push_back(sample_row(16'sh8000));
    plan.push_back(checked_row(16'sh8001, 16'sh8001, 28'd7, 1'b1));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        write_reg(plan[i].index, plan[i].data);
      end else begin
        offer_sample(plan[i].value, plan[i].typed, plan[i].want);
      end
    end

    for (int stage = 0; stage < 3; stage++) begin
      case (stage)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct = 70;
          run_phase(11'd1, 11'd1, 11'd511, 11'd31, 11'd31, 1, 1'b0, sent);
        end
        1: begin
          send_idle_pct = 70;
          recv_idle_pct = 32;
          run_phase(11'd2, 11'd20, 11'd1, 11'd1, 11'd1, 1, 1'b0, sent);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          run_phase(11'd40, 11'd1, 11'd1, 11'd16, 11'd3, 1, 1'b1, sent);
        end
      endcase
      stage_items = 0;
      while (stage_items < STAGE_ITEMS) begin
        h = ($urandom_range(0, 9) == 0) ? 11'd0 : CFG_BITS'($urandom_range(1, 5));
        w = ($urandom_range(0, 9) == 0) ? 11'd0 : CFG_BITS'($urandom_range(1, 12));
        c = ($urandom_range(0, 9) == 0) ? 11'd0 : CFG_BITS'($urandom_range(1, 2));
        c = c | (CFG_BITS'($urandom_range(0, 3)) << CNT_BITS);
        wh = ($urandom_range(0, 7) == 0) ? CFG_BITS'($urandom_range(16, 31))
                                         : CFG_BITS'($urandom_range(0, 5));
        wh = wh | (CFG_BITS'($urandom_range(0, 63)) << WSZ_BITS);
        ww = ($urandom_range(0, 7) == 0) ? CFG_BITS'($urandom_range(16, 31))
                                         : CFG_BITS'($urandom_range(0, 5));
        ww = ww | (CFG_BITS'($urandom_range(0, 63)) << WSZ_BITS);
        run_phase(h, w, c, wh, ww, $urandom_range(1, 3), 1'b0, sent);
        stage_items += sent;
      end
    end

    samples_ch.valid <= 1'b0;
    while (pending_pools.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("max_pool_with_argmax_top_test OK");
    end else begin
      $display("max_pool_with_argmax_top_test NOT OK");
    end
    $finish;
  end

  initial begin : drain
    int      hold_left;
    bit      hold_served;
    pooled_t got, want;
    hold_left = 0;
    hold_served = 1'b0;
    results_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && results_ch.valid && results_ch.ready) begin
        got = '{results_ch.max_value, results_ch.source_index, results_ch.last_of_map};
        if (pending_pools.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: max %0d index %0d last %0b", got.max_value,
                     got.source_index, got.last_of_map);
          end
        end else begin
          want = pending_pools.pop_front();
          if (got.max_value !== want.max_value || got.source_index !== want.source_index ||
              got.last_of_map !== want.last_of_map) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display({"mismatch: expected max %0d index %0d last %0b,",
                        " got max %0d index %0d last %0b"},
                       want.max_value, want.source_index, want.last_of_map,
                       got.max_value, got.source_index, got.last_of_map);
            end
          end
        end
      end
      if (hold_request && !hold_served) begin
        hold_left = HOLD_CYCLES;
        hold_served = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        results_ch.ready <= 1'b0;
      end else begin
        results_ch.ready <= !(recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_wr_en || (samples_ch.valid && samples_ch.ready) ||
          (results_ch.valid && results_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("max_pool_with_argmax_top_test NOT OK");
    $finish;
  end

endmodule

FILE: max_pool_with_argmax_top.f
rtl/mpa_pkg.sv
rtl/mpa_in_if.sv
rtl/mpa_out_if.sv
rtl/mpa_scan.sv
rtl/mpa_column_unit.sv
rtl/max_pool_with_argmax_top.sv
tb/max_pool_with_argmax_top_test.sv
